// ===== rtl/gcrb_pkg.sv =====
package gcrb_pkg;

	localparam int CORDIC_STEPS = 32;
	localparam int ATAN_ROWS    = 48;
	localparam int STEPS        = (CORDIC_STEPS > ATAN_ROWS) ? ATAN_ROWS : CORDIC_STEPS;

	// Q30 working word: wide enough for pi, for CORDIC growth and for 2*sin
	localparam int QW = 36;
	// integer square root: radicand up to 2^60, one result bit per cell
	localparam int SQW      = 62;
	localparam int SQ_STEPS = 31;

	// total register stages from request accept to result register
	localparam int LAT = 2 + STEPS + 3 + SQ_STEPS + 1 + STEPS + 2;

	localparam longint Q30_ONE      = 64'sd1073741824;
	localparam longint CORDIC_GAIN  = 64'sd652032874;
	localparam longint PI_Q30       = 64'sd3373259426;
	localparam longint HALF_PI_Q30  = 64'sd1686629713;
	localparam longint RAD_PER_UNIT = 64'sd2012227627;
	localparam longint MDEG_PER_RAD = 64'sd1877468103;
	localparam longint DIAMETER_CM  = 64'sd1274200000;
	localparam longint RANGE_MAX    = 64'sd2001508680;
	localparam longint LAT_LIMIT    = 64'sd900000000;
	localparam longint LON_HALF     = 64'sd1800000000;
	localparam longint LON_TURN     = 64'sd3600000000;
	localparam longint MDEG_TURN    = 64'sd360000;

	typedef logic signed [QW-1:0] q_t;

	typedef struct packed {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
		logic                 hold;
	} cord_t;

	typedef struct packed {
		logic [SQW-1:0] v;
		logic [SQW-1:0] r;
	} sq_t;

	typedef enum logic {
		MODE_ROTATE = 1'b0,
		MODE_VECTOR = 1'b1
	} cord_mode_t;

	// round(atan(2^-i) * 2^30)
	function automatic q_t atan_row(input logic [5:0] i);
		q_t t;
		case (i)
			6'd0: t = q_t'(843314857);
			6'd1: t = q_t'(497837829);
			6'd2: t = q_t'(263043837);
			6'd3: t = q_t'(133525159);
			6'd4: t = q_t'(67021687);
			6'd5: t = q_t'(33543516);
			6'd6: t = q_t'(16775851);
			6'd7: t = q_t'(8388437);
			6'd8: t = q_t'(4194283);
			6'd9: t = q_t'(2097149);
			default: begin
				if (i <= 6'd30)
					t = q_t'(64'sd1 <<< (6'd30 - i));
				else
					t = '0;
			end
		endcase
		return t;
	endfunction

	// rounded right shift, ties away from zero
	function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
	                                           input logic [5:0] s);
		logic [63:0] u;
		logic [63:0] r;
		u = v[63] ? 64'(-v) : 64'(v);
		r = (u + (64'd1 << (s - 6'd1))) >> s;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic q_t mulq(input q_t a, input q_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return q_t'(rsh(p, 6'd30));
	endfunction

endpackage

// ===== rtl/gcrb_if.sv =====
interface gcrb_in_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] here_lat;
	logic signed [31:0] here_lon;
	logic signed [30:0] goal_lat;
	logic signed [31:0] goal_lon;

	modport source (output valid, here_lat, here_lon, goal_lat, goal_lon, input ready);
	modport sink   (input valid, here_lat, here_lon, goal_lat, goal_lon, output ready);
endinterface

interface gcrb_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] range_cm;
	logic [18:0] heading_mdeg;

	modport source (output valid, range_cm, heading_mdeg, input ready);
	modport sink   (input valid, range_cm, heading_mdeg, output ready);
endinterface

// ===== rtl/gcrb_cordic_cell.sv =====
module gcrb_cordic_cell (
	input  logic             clk,
	input  logic             en,
	input  logic [5:0]       idx,
	input  gcrb_pkg::cord_mode_t mode,
	input  gcrb_pkg::cord_t  d,
	output gcrb_pkg::cord_t  q
);
	import gcrb_pkg::*;

	q_t    dx;
	q_t    dy;
	q_t    t;
	logic  sigma;
	cord_t nxt;

	always_comb begin
		dx    = d.y >>> idx;
		dy    = d.x >>> idx;
		t     = atan_row(idx);
		sigma = (mode == MODE_VECTOR) ? !(d.y > 0) : (d.z >= 0);
		nxt   = d;
		if (!d.hold) begin
			if (sigma) begin
				nxt.x = d.x - dx;
				nxt.y = d.y + dy;
				nxt.z = d.z - t;
			end else begin
				nxt.x = d.x + dx;
				nxt.y = d.y - dy;
				nxt.z = d.z + t;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nxt;
	end
endmodule

// ===== rtl/gcrb_sqrt_cell.sv =====
module gcrb_sqrt_cell (
	input  logic          clk,
	input  logic          en,
	input  logic [4:0]    idx,
	input  gcrb_pkg::sq_t d,
	output gcrb_pkg::sq_t q
);
	import gcrb_pkg::*;

	logic [SQW-1:0] b;
	logic [SQW-1:0] rb;
	sq_t            nxt;

	always_comb begin
		b  = SQW'(1) << (6'd60 - {idx, 1'b0});
		rb = d.r + b;
		if (d.v >= rb) begin
			nxt.v = d.v - rb;
			nxt.r = (d.r >> 1) + b;
		end else begin
			nxt.v = d.v;
			nxt.r = d.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nxt;
	end
endmodule

// ===== rtl/great_circle_range_bearing_top.sv =====
// Great-circle range and initial bearing. Each request carries a current and a
// destination position (latitude and longitude in signed 1e-7 degree); each
// produces one result: the haversine distance in centimetres on a 6371 km
// sphere (0..2001508680) and the initial bearing clockwise from north in
// millidegrees (0..359999, 0 when the points coincide). Latitudes beyond the
// poles saturate; any longitude pair is accepted. The datapath is a fully
// pipelined row of CORDIC and square-root cells, so a new request is taken
// every cycle unless the result is stalled; the sine/cosine chain, the
// 31-cell square-root chain and the atan2 chain run in series. A stalled
// result holds the whole row, while the entry stage still takes one more
// request if it is empty.
module great_circle_range_bearing_top (
	input  logic        clk,
	input  logic        arst_n,
	gcrb_in_if.sink     pos,
	gcrb_out_if.source  res
);
	import gcrb_pkg::*;

	logic           adv;
	logic           acc;
	logic [LAT-1:0] vld_q;

	// advance the row when the result register is free or being drained
	assign adv       = !vld_q[LAT-1] || res.ready;
	assign pos.ready = adv || !vld_q[0];
	assign acc       = pos.valid && pos.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end else begin
			vld_q[0] <= vld_q[0] | acc;
		end
	end

	// ---- stage 1: clamp latitudes, form differences, wrap longitude ----
	logic signed [30:0] lat1_c, lat2_c;
	logic signed [33:0] dl_raw;
	logic signed [31:0] dl_w;
	logic signed [30:0] lat1_s1, lat2_s1;
	logic signed [31:0] dp_s1, dl_s1;

	always_comb begin
		if (64'(pos.here_lat) > LAT_LIMIT)       lat1_c = 31'(LAT_LIMIT);
		else if (64'(pos.here_lat) < -LAT_LIMIT) lat1_c = 31'(-LAT_LIMIT);
		else                                     lat1_c = pos.here_lat;
		if (64'(pos.goal_lat) > LAT_LIMIT)       lat2_c = 31'(LAT_LIMIT);
		else if (64'(pos.goal_lat) < -LAT_LIMIT) lat2_c = 31'(-LAT_LIMIT);
		else                                     lat2_c = pos.goal_lat;
		dl_raw = 34'(pos.goal_lon) - 34'(pos.here_lon);
		// one whole turn always suffices for a 32-bit longitude pair
		if (64'(dl_raw) >= LON_HALF)      dl_w = 32'(dl_raw - 34'(LON_TURN));
		else if (64'(dl_raw) < -LON_HALF) dl_w = 32'(dl_raw + 34'(LON_TURN));
		else                              dl_w = 32'(dl_raw);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			lat1_s1 <= lat1_c;
			lat2_s1 <= lat2_c;
			dp_s1   <= 32'(lat2_c) - 32'(lat1_c);
			dl_s1   <= dl_w;
		end
	end

	// ---- stage 2: degrees to radians ----
	logic signed [63:0] plat1_s2, plat2_s2, pdp_s2, pdl_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			plat1_s2 <= 64'(lat1_s1) * RAD_PER_UNIT;
			plat2_s2 <= 64'(lat2_s1) * RAD_PER_UNIT;
			pdp_s2   <= 64'(dp_s1) * RAD_PER_UNIT;
			pdl_s2   <= 64'(dl_s1) * RAD_PER_UNIT;
		end
	end

	// ---- sine/cosine chains: lat1, lat2, half dlat, half dlon ----
	cord_t sc [4][STEPS+1];

	for (genvar j = 0; j < 4; j++) begin : g_sc_init
		assign sc[j][0].x    = q_t'(CORDIC_GAIN);
		assign sc[j][0].y    = '0;
		assign sc[j][0].hold = 1'b0;
	end
	assign sc[0][0].z = q_t'(rsh(plat1_s2, 6'd30));
	assign sc[1][0].z = q_t'(rsh(plat2_s2, 6'd30));
	assign sc[2][0].z = q_t'(rsh(pdp_s2, 6'd31));
	assign sc[3][0].z = q_t'(rsh(pdl_s2, 6'd31));

	for (genvar j = 0; j < 4; j++) begin : g_sc
		for (genvar i = 0; i < STEPS; i++) begin : g_cell
			gcrb_cordic_cell u_cell (
				.clk  (clk),
				.en   (adv),
				.idx  (6'(i)),
				.mode (MODE_ROTATE),
				.d    (sc[j][i]),
				.q    (sc[j][i+1])
			);
		end
	end

	// ---- stage 4: first products ----
	q_t p_sh_s4, p_c12_s4, p_sl2_s4, p_slcl_s4, p_c1s2_s4, p_s1c2_s4, c2_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_sh_s4   <= mulq(sc[2][STEPS].y, sc[2][STEPS].y);
			p_c12_s4  <= mulq(sc[0][STEPS].x, sc[1][STEPS].x);
			p_sl2_s4  <= mulq(sc[3][STEPS].y, sc[3][STEPS].y);
			p_slcl_s4 <= mulq(sc[3][STEPS].y, sc[3][STEPS].x);
			p_c1s2_s4 <= mulq(sc[0][STEPS].x, sc[1][STEPS].y);
			p_s1c2_s4 <= mulq(sc[0][STEPS].y, sc[1][STEPS].x);
			c2_s4     <= sc[1][STEPS].x;
		end
	end

	// ---- stage 5: haversine term, bearing vector parts ----
	q_t          a_raw, cos_dl;
	logic [30:0] a_c;
	logic [30:0] a_s5;
	q_t          by_s5, t_s5, c1s2_s5;

	always_comb begin
		a_raw  = p_sh_s4 + mulq(p_c12_s4, p_sl2_s4);
		if (a_raw < 0)                     a_c = '0;
		else if (64'(a_raw) > Q30_ONE)     a_c = 31'(Q30_ONE);
		else                               a_c = 31'(a_raw);
		cos_dl = q_t'(Q30_ONE) - (p_sl2_s4 <<< 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s5    <= a_c;
			by_s5   <= mulq(p_slcl_s4 <<< 1, c2_s4);
			t_s5    <= mulq(p_s1c2_s4, cos_dl);
			c1s2_s5 <= p_c1s2_s4;
		end
	end

	// ---- stage 6: radicands and bearing x ----
	q_t          bx_s6, by_s6;
	logic [30:0] a_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			bx_s6 <= c1s2_s5 - t_s5;
			by_s6 <= by_s5;
			a_s6  <= a_s5;
		end
	end

	// ---- square-root chains: sqrt(a) and sqrt(1-a) ----
	sq_t sqa [SQ_STEPS+1];
	sq_t sqb [SQ_STEPS+1];

	assign sqa[0].v = SQW'({a_s6, 30'b0});
	assign sqa[0].r = '0;
	assign sqb[0].v = SQW'({31'(Q30_ONE) - a_s6, 30'b0});
	assign sqb[0].r = '0;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		gcrb_sqrt_cell u_sqa (
			.clk (clk),
			.en  (adv),
			.idx (5'(k)),
			.d   (sqa[k]),
			.q   (sqa[k+1])
		);
		gcrb_sqrt_cell u_sqb (
			.clk (clk),
			.en  (adv),
			.idx (5'(k)),
			.d   (sqb[k]),
			.q   (sqb[k+1])
		);
	end

	// hold the bearing vector alongside the square roots
	q_t bx_q [SQ_STEPS];
	q_t by_q [SQ_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			bx_q[0] <= bx_s6;
			by_q[0] <= by_s6;
			for (int k = 1; k < SQ_STEPS; k++) begin
				bx_q[k] <= bx_q[k-1];
				by_q[k] <= by_q[k-1];
			end
		end
	end

	// ---- stage 7: atan2 set-up for both angles ----
	function automatic cord_t vec_prep(input q_t x, input q_t y);
		cord_t c;
		c.x    = x;
		c.y    = y;
		c.z    = '0;
		c.hold = 1'b0;
		if (y == 0) begin
			// on the x axis: zero or pi, skip the rotation
			c.hold = 1'b1;
			c.z    = (x < 0) ? q_t'(PI_Q30) : '0;
		end else if (x == 0) begin
			c.hold = 1'b1;
			c.z    = (y > 0) ? q_t'(HALF_PI_Q30) : q_t'(-HALF_PI_Q30);
		end else if (x < 0) begin
			// fold into the right half plane
			c.z = (y > 0) ? q_t'(PI_Q30) : q_t'(-PI_Q30);
			c.x = -x;
			c.y = -y;
		end
		return c;
	endfunction

	cord_t av [2][STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			av[0][0] <= vec_prep(q_t'(sqb[SQ_STEPS].r), q_t'(sqa[SQ_STEPS].r));
			av[1][0] <= vec_prep(bx_q[SQ_STEPS-1], by_q[SQ_STEPS-1]);
		end
	end

	for (genvar j = 0; j < 2; j++) begin : g_av
		for (genvar i = 0; i < STEPS; i++) begin : g_cell
			gcrb_cordic_cell u_cell (
				.clk  (clk),
				.en   (adv),
				.idx  (6'(i)),
				.mode (MODE_VECTOR),
				.d    (av[j][i]),
				.q    (av[j][i+1])
			);
		end
	end

	// ---- stage 8: scale angles ----
	logic signed [63:0] rprod_s8, hprod_s8;
	q_t                 zc;

	always_comb begin
		zc = (av[0][STEPS].z < 0) ? '0 : av[0][STEPS].z;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rprod_s8 <= 64'(zc) * DIAMETER_CM;
			hprod_s8 <= 64'(av[1][STEPS].z) * MDEG_PER_RAD;
		end
	end

	// ---- stage 9: round, clamp, wrap into the result register ----
	logic signed [63:0] rng, md0, md1, md2;
	logic [30:0]        range_s9;
	logic [18:0]        mdeg_s9;

	always_comb begin
		rng = rsh(rprod_s8, 6'd30);
		if (rng > RANGE_MAX)
			rng = RANGE_MAX;
		md0 = rsh(hprod_s8, 6'd45);
		md1 = (md0 < 0) ? md0 + MDEG_TURN : md0;
		md2 = (md1 >= MDEG_TURN) ? md1 - MDEG_TURN : md1;
		if (md2 < 0)
			md2 = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			range_s9 <= 31'(rng);
			mdeg_s9  <= 19'(md2);
		end
	end

	assign res.valid        = vld_q[LAT-1];
	assign res.range_cm     = range_s9;
	assign res.heading_mdeg = mdeg_s9;
endmodule

// ===== rtl/gcrb_checker.sv =====
module gcrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] range_cm,
	input logic [18:0] heading_mdeg
);
	import gcrb_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(range_cm) && $stable(heading_mdeg))
		else $error("stalled result changed");

	a_heading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 64'(heading_mdeg) < MDEG_TURN)
		else $error("heading out of range");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 64'(range_cm) <= RANGE_MAX)
		else $error("range out of range");

	// a draining output frees the row, so the request side must be open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("request refused while row advances");
endmodule

bind great_circle_range_bearing_top gcrb_checker u_gcrb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (pos.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.range_cm     (res.range_cm),
	.heading_mdeg (res.heading_mdeg)
);

// ===== tb/great_circle_range_bearing_top_test.sv =====
`timescale 1ns / 100ps

module great_circle_range_bearing_top_test;
	import gcrb_pkg::*;

	localparam int ITEMS       = 1000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN       = LAT + 40;

	logic clk;
	logic arst_n;
	int   cycle = 0;
	int   rx_cycle = 0;

	gcrb_in_if  pos ();
	gcrb_out_if res ();

	great_circle_range_bearing_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pos    (pos.sink),
		.res    (res.source)
	);

	typedef struct {
		logic [30:0] range_cm;
		logic [18:0] heading_mdeg;
	} fix_t;

	// Scoreboard: predicts range and heading for each accepted request and
	// checks results against them in order.
	class route_scoreboard;
		fix_t expected_fixes[$];
		int   mismatches;

		function automatic longint rnd_shift(longint v, int s);
			longint unsigned u, r;
			u = (v < 0) ? longint'(-v) : v;
			r = (u + (64'd1 << (s - 1))) >> s;
			return (v < 0) ? -longint'(r) : longint'(r);
		endfunction

		function automatic longint qmul(longint a, longint b);
			return rnd_shift(a * b, 30);
		endfunction

		function automatic longint arctan_step(int i);
			longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
				33543516, 16775851, 8388437, 4194283, 2097149};
			if (i < 10)
				return head[i];
			if (i <= 30)
				return 64'sd1 <<< (30 - i);
			return 0;
		endfunction

		function automatic void rotate(longint ang, output longint s, output longint c);
			longint x, y, z, dx, dy;
			x = CORDIC_GAIN;
			y = 0;
			z = ang;
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= arctan_step(i);
				end else begin
					x += dx; y -= dy; z += arctan_step(i);
				end
			end
			s = y;
			c = x;
		endfunction

		function automatic longint arc_angle(longint x, longint y);
			longint z, dx, dy;
			z = 0;
			if (y == 0)
				return (x < 0) ? PI_Q30 : 0;
			if (x == 0)
				return (y > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
			if (x < 0) begin
				z = (y > 0) ? PI_Q30 : -PI_Q30;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; z += arctan_step(i);
				end else begin
					x -= dx; y += dy; z -= arctan_step(i);
				end
			end
			return z;
		endfunction

		function automatic longint root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return longint'(r);
		endfunction

		function automatic longint sat_lat(longint v);
			if (v > LAT_LIMIT) return LAT_LIMIT;
			if (v < -LAT_LIMIT) return -LAT_LIMIT;
			return v;
		endfunction

		function automatic fix_t predict_fix(logic signed [30:0] h_lat, logic signed [31:0] h_lon,
				logic signed [30:0] g_lat, logic signed [31:0] g_lon);
			longint lat1, lat2, dl, dp, s1, c1, s2, c2, sh, ch, sl, cl;
			longint hav, zc, span_cm, sin_dl, cos_dl, by, bx, bz, mdeg;
			fix_t f;
			lat1 = sat_lat(longint'(h_lat));
			lat2 = sat_lat(longint'(g_lat));
			dl = longint'(g_lon) - longint'(h_lon);
			dp = lat2 - lat1;
			while (dl >= LON_HALF) dl -= LON_TURN;
			while (dl < -LON_HALF) dl += LON_TURN;
			rotate(rnd_shift(lat1 * RAD_PER_UNIT, 30), s1, c1);
			rotate(rnd_shift(lat2 * RAD_PER_UNIT, 30), s2, c2);
			rotate(rnd_shift(dp * RAD_PER_UNIT, 31), sh, ch);
			rotate(rnd_shift(dl * RAD_PER_UNIT, 31), sl, cl);
			hav = qmul(sh, sh) + qmul(qmul(c1, c2), qmul(sl, sl));
			if (hav < 0) hav = 0;
			if (hav > Q30_ONE) hav = Q30_ONE;
			zc = arc_angle(root(longint'(Q30_ONE - hav) << 30), root(hav << 30));
			if (zc < 0) zc = 0;
			span_cm = rnd_shift(zc * DIAMETER_CM, 30);
			if (span_cm > RANGE_MAX) span_cm = RANGE_MAX;
			sin_dl = 2 * qmul(sl, cl);
			cos_dl = Q30_ONE - 2 * qmul(sl, sl);
			by = qmul(sin_dl, c2);
			bx = qmul(c1, s2) - qmul(qmul(s1, c2), cos_dl);
			bz = arc_angle(bx, by);
			mdeg = rnd_shift(bz * MDEG_PER_RAD, 45);
			if (mdeg < 0) mdeg += MDEG_TURN;
			if (mdeg >= MDEG_TURN) mdeg -= MDEG_TURN;
			if (mdeg < 0) mdeg = 0;
			f.range_cm = span_cm[30:0];
			f.heading_mdeg = mdeg[18:0];
			return f;
		endfunction

		function void note_request(logic signed [30:0] h_lat, logic signed [31:0] h_lon,
				logic signed [30:0] g_lat, logic signed [31:0] g_lon);
			expected_fixes.push_back(predict_fix(h_lat, h_lon, g_lat, g_lon));
		endfunction

		task report(string what);
			$display("mismatch at cycle %0d: %s", cycle, what);
			mismatches++;
		endtask

		task check_fix(logic [30:0] range_cm, logic [18:0] heading_mdeg);
			fix_t f;
			if (expected_fixes.size() == 0) begin
				report($sformatf("unexpected result range %0d heading %0d",
					range_cm, heading_mdeg));
				return;
			end
			f = expected_fixes.pop_front();
			if (range_cm !== f.range_cm)
				report($sformatf("range_cm %0d, want %0d", range_cm, f.range_cm));
			if (heading_mdeg !== f.heading_mdeg)
				report($sformatf("heading_mdeg %0d, want %0d", heading_mdeg, f.heading_mdeg));
		endtask
	endclass

	route_scoreboard fixes = new();

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Cycle counter doubles as the watchdog.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: check on every accepted result, then pick next ready.
	// Ready stays high for a long window early on, drops for a long hold-off
	// while requests are still being offered so the pipeline fills and stalls
	// the request side, and otherwise drops at random with a chance of 13 in a hundred.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (arst_n && res.valid && res.ready)
			fixes.check_fix(res.range_cm, res.heading_mdeg);
		if (!arst_n)
			res.ready <= 1'b0;
		else if (rx_cycle >= 600 && rx_cycle < 900)
			res.ready <= 1'b0;
		else if (rx_cycle >= 200 && rx_cycle < 500)
			res.ready <= 1'b1;
		else
			res.ready <= ($urandom_range(0, 99) >= 13);
	end

	// Offer one request and hold it until it is taken. Valid is left high;
	// the caller drops it only when it idles.
	task send_position(int h_lat, int h_lon, int g_lat, int g_lon);
		pos.valid    <= 1'b1;
		pos.here_lat <= 31'(h_lat);
		pos.here_lon <= h_lon;
		pos.goal_lat <= 31'(g_lat);
		pos.goal_lon <= g_lon;
		@(posedge clk);
		while (!pos.ready)
			@(posedge clk);
		fixes.note_request(31'(h_lat), h_lon, 31'(g_lat), g_lon);
	endtask

	// Random gap after a request, skipped inside the no-idle window.
	task request_gap(int n);
		if (n >= 300 && n < 500)
			return;
		while ($urandom_range(0, 99) < 13) begin
			pos.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic signed [30:0] rand_lat();
		if ($urandom_range(0, 9) == 0)
			return 31'($urandom);
		return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
	endfunction

	function automatic logic signed [31:0] rand_lon();
		if ($urandom_range(0, 3) == 0)
			return 32'($urandom);
		return 32'(longint'($urandom_range(0, 32'd3599999999)) - 64'sd1800000000);
	endfunction

	initial begin
		logic signed [30:0] la, lb;
		logic signed [31:0] oa, ob;
		int n;
		arst_n       = 1'b0;
		pos.valid    = 1'b0;
		pos.here_lat = '0;
		pos.here_lon = '0;
		pos.goal_lat = '0;
		pos.goal_lon = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coincident points: range and heading zero
		send_position(0, 0, 0, 0);
		send_position(455000000, -1220000000, 455000000, -1220000000);
		// due north / due south along a meridian
		send_position(0, 100000000, 300000000, 100000000);
		send_position(300000000, 100000000, -300000000, 100000000);
		// along the equator: east and west, exact axis of atan2
		send_position(0, 0, 0, 10000000);
		send_position(0, 0, 0, -10000000);
		// poles and antipodes
		send_position(900000000, 0, -900000000, 0);
		send_position(0, 0, 0, 1800000000);
		send_position(0, -1800000000, 0, 1800000000);
		send_position(-900000000, 123456789, 900000000, -987654321);
		// latitudes beyond the poles saturate; field extremes
		send_position(31'sh3FFFFFFF, 0, 31'sh40000000, 0);
		send_position(31'sh40000000, 32'sh7FFFFFFF, 31'sh3FFFFFFF, 32'sh80000000);
		send_position(-1, -1, 1, 1);
		send_position(899999999, 32'sh80000000, -899999999, 32'sh7FFFFFFF);
		// longitude wrap across the date line
		send_position(100000000, 1790000000, 100000000, -1790000000);
		send_position(-100000000, -1795000000, -100000000, 1795000000);
		// tiny separation, near-antipodal
		send_position(515000000, -1000000, 515000001, -1000000);
		send_position(10000000, 0, -10000000, 1799999999);

		for (n = 0; n < ITEMS; n++) begin
			la = rand_lat();
			oa = rand_lon();
			if ($urandom_range(0, 4) == 0) begin
				// nearby destination
				lb = la + 31'($signed($urandom_range(0, 20000)) - 10000);
				ob = oa + 32'($signed($urandom_range(0, 20000)) - 10000);
			end else begin
				lb = rand_lat();
				ob = rand_lon();
			end
			send_position(int'(la), oa, int'(lb), ob);
			request_gap(n);
		end
		pos.valid <= 1'b0;

		// drain: wait for every result, then linger for stray ones
		while (fixes.expected_fixes.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fixes.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
